[src/rbd_pkg.sv]
// ----------------------------------------------------------------------------
// rbd_pkg
// Shared types, constants and helpers for the 2x2 RGB box downsampler.
// ----------------------------------------------------------------------------
package rbd_pkg;

	// Line geometry
	localparam int MAX_WIDTH    = 4096;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int LINE_DEPTH   = MAX_WIDTH / 2;

	// Field and counter widths
	localparam int CHAN_W  = 8;
	localparam int PSUM_W  = CHAN_W + 1;
	localparam int CFG_W   = 13;
	localparam int CFG_IDX_W = 2;
	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int SLOT_W  = $clog2(LINE_DEPTH);
	localparam int ROW_W   = $clog2(HEIGHT_LIMIT);
	localparam int WCMP_W  = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
	localparam int HCMP_W  = (ROW_W + 1 > CFG_W) ? ROW_W + 1 : CFG_W;

	// Register reset values
	localparam int WIDTH_RST  = 1920;
	localparam int HEIGHT_RST = 1080;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_LINE_WIDTH   = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1
	} reg_idx_t;

	// One line buffer entry: per-channel sums of a horizontal pixel pair
	typedef struct packed {
		logic [PSUM_W-1:0] r;
		logic [PSUM_W-1:0] g;
		logic [PSUM_W-1:0] b;
	} pair_sum_t;

	// Even, at least 2, saturated to the line limit
	function automatic logic [WCMP_W-1:0] eff_width(logic [CFG_W-1:0] v);
		logic [WCMP_W-1:0] e;
		e = WCMP_W'(v) & ~WCMP_W'(1);
		if (e < WCMP_W'(2))
			e = WCMP_W'(2);
		else if (e > WCMP_W'(MAX_WIDTH))
			e = WCMP_W'(MAX_WIDTH) & ~WCMP_W'(1);
		return e;
	endfunction

	function automatic logic [HCMP_W-1:0] eff_height(logic [CFG_W-1:0] v);
		logic [HCMP_W-1:0] e;
		e = HCMP_W'(v) & ~HCMP_W'(1);
		if (e < HCMP_W'(2))
			e = HCMP_W'(2);
		else if (e > HCMP_W'(HEIGHT_LIMIT))
			e = HCMP_W'(HEIGHT_LIMIT) & ~HCMP_W'(1);
		return e;
	endfunction

endpackage

[src/rbd_cfg_if.sv]
// ----------------------------------------------------------------------------
// rbd_cfg_if
// Register write channel: index and data with a valid/ready transfer.
// ----------------------------------------------------------------------------
interface rbd_cfg_if
	import rbd_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

[src/rbd_in_if.sv]
// ----------------------------------------------------------------------------
// rbd_in_if
// Input pixel channel: one RGB888 pixel per transfer.
// ----------------------------------------------------------------------------
interface rbd_in_if
	import rbd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red_in;
	logic [CHAN_W-1:0] green_in;
	logic [CHAN_W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink   (input valid, input red_in, input green_in, input blue_in,
		output ready);
endinterface

[src/rbd_out_if.sv]
// ----------------------------------------------------------------------------
// rbd_out_if
// Output pixel channel: one averaged RGB888 pixel and a row end flag.
// ----------------------------------------------------------------------------
interface rbd_out_if
	import rbd_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red_out;
	logic [CHAN_W-1:0] green_out;
	logic [CHAN_W-1:0] blue_out;
	logic              row_end;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output row_end, input ready);
	modport sink   (input valid, input red_out, input green_out, input blue_out,
		input row_end, output ready);
endinterface

[src/rbd_line_ram.sv]
// ----------------------------------------------------------------------------
// rbd_line_ram
// Line buffer of pair sums: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rbd_line_ram
	import rbd_pkg::*;
(
	input  logic              clk,
	input  logic              wr_en,
	input  logic [SLOT_W-1:0] wr_addr,
	input  pair_sum_t         wr_data,
	input  logic              rd_en,
	input  logic [SLOT_W-1:0] rd_addr,
	output pair_sum_t         rd_data
);

	pair_sum_t mem [LINE_DEPTH];
	pair_sum_t rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

[src/rgb_box_downsample_2x2_core.sv]
// ----------------------------------------------------------------------------
// rgb_box_downsample_2x2_core
// 2x2 box filter downsampler for RGB888 raster streams.
// ----------------------------------------------------------------------------
// Pipeline: 2 register stages; a result passes from its odd-row, odd-column
//   pixel transfer through stage 1 and then the output register.
// Throughput: 1 input pixel per cycle unless the output stalls, set by the
//   single line RAM port pair (even rows write, odd rows read, per pixel pair).
// One output per four input pixels; output stalls hold the pipe until taken.
// Reset: counters and pair register cleared, size 1920x1080; the line RAM is
//   not cleared and needs no clearing pass.
module rgb_box_downsample_2x2_core
	import rbd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	rbd_cfg_if.sink  cfg,
	rbd_in_if.sink   pixel,
	rbd_out_if.source box
);

	// Configuration: effective sizes stored directly
	logic [WCMP_W-1:0] width_q;
	logic [HCMP_W-1:0] height_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WCMP_W'(WIDTH_RST);
			height_q <= HCMP_W'(HEIGHT_RST);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_LINE_WIDTH:   width_q  <= eff_width(cfg.data);
				REG_IMAGE_HEIGHT: height_q <= eff_height(cfg.data);
				default: ;
			endcase
		end
	end

	// Pipeline handshake
	logic      valid_s1;
	logic      out_valid_q;
	logic      out_adv;
	logic      s1_adv;
	logic      in_xfer;

	assign out_adv     = !out_valid_q || box.ready;
	assign s1_adv      = out_adv;
	assign pixel.ready = !valid_s1 || s1_adv;
	assign in_xfer     = pixel.valid && pixel.ready;

	// Position counters
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CHAN_W-1:0] left_r_q, left_g_q, left_b_q;
	logic              last_col;
	logic              last_row;
	logic              odd_col;
	logic              odd_row;

	assign last_col = (WCMP_W'(col_q) + WCMP_W'(1)) >= width_q;
	assign last_row = (HCMP_W'(row_q) + HCMP_W'(1)) >= height_q;
	assign odd_col  = col_q[0];
	assign odd_row  = row_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_xfer) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Even-column pixel of the current pair
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_r_q <= '0;
			left_g_q <= '0;
			left_b_q <= '0;
		end else if (in_xfer && !odd_col) begin
			left_r_q <= pixel.red_in;
			left_g_q <= pixel.green_in;
			left_b_q <= pixel.blue_in;
		end
	end

	// Horizontal pair sum
	pair_sum_t pair;
	assign pair.r = PSUM_W'(left_r_q) + PSUM_W'(pixel.red_in);
	assign pair.g = PSUM_W'(left_g_q) + PSUM_W'(pixel.green_in);
	assign pair.b = PSUM_W'(left_b_q) + PSUM_W'(pixel.blue_in);

	// Line RAM: store on even rows, fetch on odd rows. The same slot is
	// written a full row before it is read, so no forwarding is needed.
	logic              ram_wr;
	logic              ram_rd;
	logic [SLOT_W-1:0] slot;
	pair_sum_t         prev;

	assign slot   = col_q[COL_W-1:1];
	assign ram_wr = in_xfer && odd_col && !odd_row;
	assign ram_rd = in_xfer && odd_col && odd_row;

	rbd_line_ram u_line_ram (
		.clk     (clk),
		.wr_en   (ram_wr),
		.wr_addr (slot),
		.wr_data (pair),
		.rd_en   (ram_rd),
		.rd_addr (slot),
		.rd_data (prev)
	);

	// Stage 1: pair sum waits for the RAM read
	pair_sum_t pair_s1;
	logic      row_end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (ram_rd)
			valid_s1 <= 1'b1;
		else if (s1_adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (ram_rd) begin
			pair_s1    <= pair;
			row_end_s1 <= last_col;
		end
	end

	// Vertical sum and floor divide by four
	logic [PSUM_W:0] sum_r, sum_g, sum_b;
	assign sum_r = (PSUM_W+1)'(prev.r) + (PSUM_W+1)'(pair_s1.r);
	assign sum_g = (PSUM_W+1)'(prev.g) + (PSUM_W+1)'(pair_s1.g);
	assign sum_b = (PSUM_W+1)'(prev.b) + (PSUM_W+1)'(pair_s1.b);

	// Output register
	logic [CHAN_W-1:0] red_q, green_q, blue_q;
	logic              row_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_adv)
			out_valid_q <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s1) begin
			red_q     <= sum_r[PSUM_W:2];
			green_q   <= sum_g[PSUM_W:2];
			blue_q    <= sum_b[PSUM_W:2];
			row_end_q <= row_end_s1;
		end
	end

	assign box.valid     = out_valid_q;
	assign box.red_out   = red_q;
	assign box.green_out = green_q;
	assign box.blue_out  = blue_q;
	assign box.row_end   = row_end_q;

	// Checks
	a_fetch_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		ram_rd |=> valid_s1)
		else $error("fetched pair did not reach stage 1");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |=> (valid_s1 && $stable(pair_s1) && $stable(prev)))
		else $error("stalled stage 1 lost its pair or RAM data");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!pixel.ready |-> (valid_s1 && out_valid_q && !box.ready))
		else $error("input stalled without a full, blocked pipe");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_wr && ram_rd))
		else $error("line RAM written and read in one cycle");

endmodule
